/* hdl/signed_radix_integer_to_ascii_core_assert.svh */
// assertion macros for the signed radix integer to ascii core
// expects clk and arst_n in the scope of the module that uses them
`ifndef SIGNED_RADIX_INTEGER_TO_ASCII_CORE_ASSERT_SVH
`define SIGNED_RADIX_INTEGER_TO_ASCII_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SRITOA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sritoa assertion failed");

// consequent checked in the cycle after the antecedent
`define SRITOA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sritoa assertion failed");

`endif

/* hdl/sritoa_pkg.sv */
// shared types and constants of the signed radix integer to ascii core
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package sritoa_pkg;

	localparam logic [4:0] RADIX_MIN = 5'd2;
	localparam logic [4:0] RADIX_MAX = 5'd16;
	localparam logic [4:0] RADIX_DEC = 5'd10;
	localparam logic [6:0] STORE_DEPTH = 7'd64;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_ALPHA_BASE = 8'h57;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// quotient bits produced per divider cycle
	localparam int DIV_BITS = 8;
	localparam int DIV_CYCLES = 64 / DIV_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_WR,
		S_CHK,
		S_RD,
		S_OUT
	} sritoa_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic digit_wr;
		logic idx_init;
		logic rd;
		logic emit_err;
		logic emit_sign;
		logic emit_digit;
	} sritoa_cmd_t;

	typedef struct packed {
		logic args_bad;
		logic more_digits;
		logic fits;
		logic sign;
		logic idx_zero;
	} sritoa_stat_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return CHAR_ZERO + {4'h0, d};
		end else begin
			return CHAR_ALPHA_BASE + {4'h0, d};
		end
	endfunction

endpackage

`default_nettype wire

/* hdl/sritoa_ctrl.sv */
// controller state machine of the signed radix integer to ascii core
// depends on sritoa_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "signed_radix_integer_to_ascii_core_assert.svh"

module sritoa_ctrl import sritoa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  sritoa_stat_t stat,
	output sritoa_cmd_t  cmd
);

	localparam int CW = $clog2(DIV_CYCLES);
	localparam logic [CW-1:0] DivLast = CW'(DIV_CYCLES - 1);

	sritoa_state_t state_q, state_d;
	logic [CW-1:0] div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (stat.args_bad) begin
					cmd.emit_err = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DivLast) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.digit_wr = 1'b1;
				if (stat.more_digits) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (!stat.fits) begin
					cmd.emit_err = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.idx_init = 1'b1;
					cmd.emit_sign = stat.sign;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				cmd.emit_digit = 1'b1;
				state_d = stat.idx_zero ? S_IDLE : S_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	`SRITOA_ASSERT_NXT(a_start_to_prep, start && !busy, state_q == S_PREP)
	`SRITOA_ASSERT_NXT(a_div_runs_full, (state_q == S_DIV) && (div_cnt_q != DivLast), state_q == S_DIV)
	`SRITOA_ASSERT_NXT(a_final_digit_ends, (state_q == S_OUT) && stat.idx_zero, state_q == S_IDLE)

endmodule

`default_nettype wire

/* hdl/sritoa_dp.sv */
// datapath of the signed radix integer to ascii core: operand registers,
// iterative divider, digit store and result registers; depends on sritoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module sritoa_dp import sritoa_pkg::*; #(
	parameter int MAX_BUF = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [63:0] value,
	input  logic        [4:0]  radix,
	input  logic        [5:0]  min_digits,
	input  logic        [6:0]  buf_size,
	input  sritoa_cmd_t        cmd,
	output sritoa_stat_t       stat,
	output logic               char_valid,
	output logic        [7:0]  out_char,
	output logic               last,
	output logic               error
);

	localparam int AW = $clog2(MAX_BUF);
	localparam logic [6:0] MaxBufW = 7'(MAX_BUF);

	logic [63:0] mag_q;
	logic [3:0]  rem_q;
	logic [4:0]  radix_q;
	logic [5:0]  pad_q;
	logic [6:0]  size_q;
	logic        sign_q;
	logic [6:0]  count_q;
	logic [6:0]  idx_q;
	logic [3:0]  rd_q;
	logic [3:0]  store_q [MAX_BUF];

	logic [63:0] uvalue;
	logic        neg;
	logic [6:0]  idx_m1;
	logic [3:0]  div_rem;
	logic [DIV_BITS-1:0] div_quo;
	logic        valid_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic        err_q;

	assign uvalue = value;
	assign neg = (radix == RADIX_DEC) && value[63];
	assign idx_m1 = idx_q - 7'd1;

	// restoring division, DIV_BITS dividend bits per cycle, msb first
	always_comb begin : div_blk
		logic [3:0] r;
		logic [4:0] t;
		r = rem_q;
		div_quo = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, mag_q[63-i]};
			if (t >= radix_q) begin
				t = t - radix_q;
				div_quo[DIV_BITS-1-i] = 1'b1;
			end
			r = t[3:0];
		end
		div_rem = r;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= radix;
			pad_q <= min_digits;
			size_q <= (buf_size > MaxBufW) ? MaxBufW : buf_size;
			sign_q <= neg;
			mag_q <= neg ? (64'd0 - uvalue) : uvalue;
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[63-DIV_BITS:0], div_quo};
		end
		if (cmd.div_step) begin
			rem_q <= div_rem;
		end else if (cmd.div_start) begin
			rem_q <= '0;
		end
		if (cmd.digit_wr && (pad_q != 6'd0)) begin
			pad_q <= pad_q - 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.load) begin
				count_q <= '0;
			end else if (cmd.digit_wr) begin
				count_q <= count_q + 7'd1;
			end
			if (cmd.idx_init) begin
				idx_q <= count_q;
			end else if (cmd.rd) begin
				idx_q <= idx_m1;
			end
		end
	end

	// digits past the buffer are never read back, so they are dropped
	always_ff @(posedge clk) begin
		if (cmd.digit_wr && (count_q < MaxBufW)) begin
			store_q[count_q[AW-1:0]] <= rem_q;
		end
		if (cmd.rd) begin
			rd_q <= store_q[idx_m1[AW-1:0]];
		end
	end

	assign stat.args_bad = (size_q == 7'd0) || (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
	// pad and count as they stand after the digit being written
	assign stat.more_digits = ((mag_q != 64'd0) || (pad_q > 6'd1))
		&& ((count_q + 7'd1) < STORE_DEPTH);
	assign stat.fits = (8'd1 + {7'd0, sign_q} + {1'b0, count_q}) <= {1'b0, size_q};
	assign stat.sign = sign_q;
	assign stat.idx_zero = (idx_q == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit_err | cmd.emit_sign | cmd.emit_digit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			char_q <= CHAR_NUL;
			last_q <= 1'b1;
			err_q <= 1'b1;
		end else if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
			err_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= digit_char(rd_q);
			last_q <= (idx_q == 7'd0);
			err_q <= 1'b0;
		end
	end

	assign char_valid = valid_q;
	assign out_char = char_q;
	assign last = last_q;
	assign error = err_q;

endmodule

`default_nettype wire

/* hdl/signed_radix_integer_to_ascii_core.sv */
// for each digit the 8-bit-per-cycle divider runs its steps, then the digit is
// written to the digit store; each character is then read back from the store
// and sent through the result register; a sign is emitted in the check state
// bad radix or empty buffer gives the error result from the prep state
// results come on a one-cycle strobe; the receiver cannot stall
// arst_n clears the controller, counters and strobe; the digit store has no reset
`timescale 1ns / 1ps
`default_nettype none

module signed_radix_integer_to_ascii_core import sritoa_pkg::*; #(
	parameter int MAX_BUF = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [63:0] value,
	input  logic        [4:0]  radix,
	input  logic        [5:0]  min_digits,
	input  logic        [6:0]  buf_size,
	output logic               char_valid,
	output logic        [7:0]  out_char,
	output logic               last,
	output logic               error
);

	sritoa_cmd_t  cmd;
	sritoa_stat_t stat;

	sritoa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	sritoa_dp #(
		.MAX_BUF (MAX_BUF)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.radix      (radix),
		.min_digits (min_digits),
		.buf_size   (buf_size),
		.cmd        (cmd),
		.stat       (stat),
		.char_valid (char_valid),
		.out_char   (out_char),
		.last       (last),
		.error      (error)
	);

endmodule

`default_nettype wire
